// ===== src/rds_pkg.sv =====
// Shared command codes, status codes and memory control types for the deque store.
`default_nettype none
package rds_pkg;

    // Command codes carried in the low bits of the input item.
    localparam logic [2:0] CMD_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK   = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT   = 3'd2;
    localparam logic [2:0] CMD_REVERSE     = 3'd3;
    localparam logic [2:0] CMD_SECOND_LAST = 3'd4;
    localparam logic [2:0] CMD_DUMP        = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    // Field widths of the stream items.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int OUT_D_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Strobes from the controller to the element memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage
`default_nettype wire

// ===== src/reversible_deque_store_unit.sv =====
// Top level of the reversible deque store: command sequencer, ring pointers and output register.
//
// A bounded double-ended store of DEPTH elements held in a ring memory with a
// front index, a fill count and a direction flag, so reverse is a flag flip.
// Push, reverse and every error case finish in the cycle the item is accepted
// and present their result on the next edge. Pop and read-second-last pass the
// registered read data of the element memory through the data state to the
// output register. A dump returns one element per cycle while the output is not
// stalled, limited by the single read port; a dump of an empty store gives one
// result with status empty. A new item is accepted only once the previous one
// has issued all its results and the output register is free or being read. The
// memory needs no clearing pass after reset: only occupied entries are ever read.
`default_nettype none
module reversible_deque_store_unit #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // command [2:0], value [34:3], zero pad [39:35]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data [31:0], status [33:32], count_now [39:34]
    output logic        m_axis_tlast
);
    import rds_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DATA = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rev, n_rev;
    logic [CW-1:0]         r_pos, n_pos;
    logic                  r_rd_last, n_rd_last;

    logic                  r_m_valid, n_m_valid;
    logic [OUT_D_W-1:0]    r_m_data, n_m_data;
    logic [STATUS_W-1:0]   r_m_status, n_m_status;
    logic [COUNT_W-1:0]    r_m_count, n_m_count;
    logic                  r_m_last, n_m_last;

    t_ram_ctl              ram_ctl;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CMD_W-1:0]      in_cmd;
    logic [VALUE_W-1:0]    in_value;
    logic                  in_acc;
    logic                  out_free;
    logic                  at_low;
    logic [CW-1:0]         pos_sel;
    logic [CW-1:0]         phys_off;
    logic [AW-1:0]         phys_addr;
    logic [VALUE_W+63:0]   value_ext;
    logic [DATA_WIDTH+63:0] rdata_ext;
    logic [OUT_D_W-1:0]    rdata_field;

    // Modular add of two values below DEPTH.
    function automatic logic [AW-1:0] wrap_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW-1:0] s;
        s = a + b;
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Count in the six-bit result field.
    function automatic logic [COUNT_W-1:0] to_cnt(input logic [CW-1:0] c);
        logic [CW+COUNT_W-1:0] t;
        t = {{COUNT_W{1'b0}}, c};
        return t[COUNT_W-1:0];
    endfunction

    // Input unpacking and handshake.
    assign in_cmd        = s_axis_tdata[CMD_W-1:0];
    assign in_value      = s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Stored value is the low DATA_WIDTH bits of the input value.
    assign value_ext = {64'd0, in_value};
    assign ram_wdata = value_ext[DATA_WIDTH-1:0];

    // Read data sign-extended from DATA_WIDTH into the result field.
    assign rdata_ext   = {{64{ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
    assign rdata_field = rdata_ext[OUT_D_W-1:0];

    // Front push goes below the run unless reversed; back push the other way.
    assign at_low = (in_cmd == CMD_PUSH_FRONT) != r_rev;

    // Physical slot of the selected logical position.
    assign phys_off  = r_rev ? (r_count - CW'(1) - pos_sel) : pos_sel;
    assign phys_addr = wrap_add(SW'(r_front), SW'(phys_off));
    assign ram_raddr = phys_addr;

    // Command sequencer.
    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_rev      = r_rev;
        n_pos      = r_pos;
        n_rd_last  = r_rd_last;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_status = r_m_status;
        n_m_count  = r_m_count;
        n_m_last   = r_m_last;
        ram_ctl    = '0;
        ram_waddr  = r_front;
        pos_sel    = r_pos;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_m_valid  = 1'b1;
                    n_m_data   = '0;
                    n_m_status = ST_OK;
                    n_m_count  = to_cnt(r_count);
                    n_m_last   = 1'b1;
                    case (in_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_m_status = ST_FULL;
                            end else begin
                                ram_ctl.wr_en = 1'b1;
                                if (at_low) begin
                                    n_front   = wrap_add(SW'(r_front), SW'(DEPTH - 1));
                                    ram_waddr = n_front;
                                end else begin
                                    ram_waddr = wrap_add(SW'(r_front), SW'(r_count));
                                end
                                n_count   = r_count + CW'(1);
                                n_m_count = to_cnt(n_count);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_m_status = ST_EMPTY;
                            end else begin
                                n_m_valid     = r_m_valid && !m_axis_tready;
                                pos_sel       = '0;
                                ram_ctl.rd_en = 1'b1;
                                n_state       = S_DATA;
                                n_rd_last     = 1'b1;
                                if (!r_rev) begin
                                    n_front = wrap_add(SW'(r_front), SW'(1));
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        CMD_SECOND_LAST: begin
                            if (r_count < CW'(2)) begin
                                n_m_status = ST_SHORT;
                            end else begin
                                n_m_valid     = r_m_valid && !m_axis_tready;
                                pos_sel       = r_count - CW'(2);
                                ram_ctl.rd_en = 1'b1;
                                n_state       = S_DATA;
                                n_rd_last     = 1'b1;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_m_status = ST_EMPTY;
                            end else begin
                                n_m_valid     = r_m_valid && !m_axis_tready;
                                pos_sel       = '0;
                                ram_ctl.rd_en = 1'b1;
                                n_state       = S_DATA;
                                n_pos         = CW'(1);
                                n_rd_last     = (r_count == CW'(1));
                            end
                        end
                        default: begin
                            n_m_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DATA: begin
                // Hand the fetched element on and fetch the next one of a dump.
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_data   = rdata_field;
                    n_m_status = ST_OK;
                    n_m_count  = to_cnt(r_count);
                    n_m_last   = r_rd_last;
                    if (r_rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        pos_sel       = r_pos;
                        ram_ctl.rd_en = 1'b1;
                        n_pos         = r_pos + CW'(1);
                        n_rd_last     = (r_pos + CW'(1) == r_count);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_pos     <= '0;
            r_rd_last <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_pos     <= n_pos;
            r_rd_last <= n_rd_last;
            r_m_valid <= n_m_valid;
        end
    end

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        r_m_data   <= n_m_data;
        r_m_status <= n_m_status;
        r_m_count  <= n_m_count;
        r_m_last   <= n_m_last;
    end

    // Element memory.
    rds_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output packing.
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_count, r_m_status, r_m_data};
    assign m_axis_tlast  = r_m_last;

    // The fill count never exceeds the memory depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // Every memory read is followed by a cycle in the data state, which hands its data on.
    a_read_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.rd_en |=> r_state == S_DATA)
        else $error("read issued without data phase");

    // A successful push grows the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.wr_en |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the count");

    // A result that is not the last of its item can only come from a dump in progress.
    a_nonlast_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_last) |-> r_state == S_DATA)
        else $error("non-final result outside a dump");

    // Reads and writes never happen in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_ctl.wr_en && ram_ctl.rd_en))
        else $error("memory read and write overlap");

endmodule
`default_nettype wire

// ===== src/rds_ram.sv =====
// Element memory: one write port and one read port with registered read data.
`default_nettype none
module rds_ram #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire rds_pkg::t_ram_ctl       i_ctl,
    input  wire [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire [DATA_WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [DATA_WIDTH-1:0]        o_rdata
);
    import rds_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no new read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
